[rtl/ppn_pkg.sv]
// Shared constants, codes and types of the pixel pedestal and noise block.
`timescale 1ns / 1ps
`default_nettype none
package ppn_pkg;
    localparam int WIN_W      = 128;
    localparam int WIN_H      = 128;
    localparam int WX_W       = $clog2(WIN_W);
    localparam int WY_W       = $clog2(WIN_H);
    localparam int BANK_AW    = WX_W - 1 + WY_W;
    localparam int BANK_DEPTH = 1 << BANK_AW;
    localparam int LANES      = 2;
    localparam int PIX_W      = 16;
    localparam int SUM_W      = 26;
    localparam int SQ_W       = 42;
    localparam int N_W        = 11;
    localparam int Q8_W       = 24;
    localparam int DIV_W      = 69;
    localparam int REM_W      = 22;
    localparam int RT_W       = 50;
    localparam int DIV_STEPS  = 69;
    localparam int SQRT_STEPS = 25;
    localparam int CNT_W      = 7;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_ROW_WORDS      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_PER_FRAME = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_X0      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_Y0      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAMES_TO_AVG  = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_ACC,
        ST_START,
        ST_CALC,
        ST_OUT
    } t_state;

    typedef enum logic [2:0] {
        CS_IDLE,
        CS_MUL,
        CS_DIVP,
        CS_VAR,
        CS_DIVV,
        CS_SQRT
    } t_calc_state;

    typedef struct packed {
        logic               we;
        logic               first;
        logic [BANK_AW-1:0] addr;
        logic [PIX_W-1:0]   pix;
    } t_acc_req;

    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic [SQ_W-1:0]  sq;
    } t_lane_out;

    typedef struct packed {
        logic            done;
        logic [Q8_W-1:0] ped;
        logic [Q8_W-1:0] noise;
    } t_calc_res;
endpackage
`default_nettype wire

[rtl/pixel_pedestal_noise_calc.sv]
// Top level: frame position tracking, two column-parity lanes and result merge.
//
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+----------------------------------
//  input    | in        | i_valid / o_stall      | i_raw_word
//  result   | out       | o_valid / i_stall      | o_win_col, o_win_row, o_pedestal_q8,
//           |           |                        | o_noise_q8, o_last
//  config   | in        | i_cfg_valid/o_cfg_ready| i_cfg_index, i_cfg_data
//
// A header word is taken in the idle state; a pixel word passes through the bank read and accumulate states.
// On the last frame each window pixel also passes through the shared
// divide and square-root unit, and waits out any output stall.
// Reset is synchronous; the sum banks are not cleared, the first frame overwrites them.
// o_stall stays high from an accepted pixel word until it is accumulated and any result of it is taken.
`timescale 1ns / 1ps
`default_nettype none
module pixel_pedestal_noise_calc (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output      logic                           o_stall,
    input  wire logic [31:0]                    i_raw_word,
    output      logic                           o_valid,
    input  wire logic                           i_stall,
    output      logic [6:0]                     o_win_col,
    output      logic [6:0]                     o_win_row,
    output      logic [23:0]                    o_pedestal_q8,
    output      logic [23:0]                    o_noise_q8,
    output      logic                           o_last,
    input  wire logic                           i_cfg_valid,
    output      logic                           o_cfg_ready,
    input  wire logic [ppn_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [ppn_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    ppn_pkg::t_state r_state, n_state;

    logic [11:0] r_row_words;
    logic [12:0] r_rows_per_frame;
    logic [11:0] r_x0;
    logic [11:0] r_y0;
    logic [9:0]  r_nf_cfg;

    logic [1:0]  r_hc;
    logic [10:0] r_col;
    logic [11:0] r_row;
    logic [9:0]  r_fc;

    logic [ppn_pkg::PIX_W-1:0] r_pix0, r_pix1;
    logic [ppn_pkg::WX_W-1:0]  r_wx0, r_wx1;
    logic [ppn_pkg::WY_W-1:0]  r_wy;
    logic [1:0]                r_pend;
    logic                      r_emit;
    logic                      r_first;
    logic [ppn_pkg::N_W-1:0]   r_n;
    logic [ppn_pkg::Q8_W-1:0]  r_ped;
    logic [ppn_pkg::Q8_W-1:0]  r_noise;

    logic        acc;
    logic [11:0] rw;
    logic [12:0] rows;
    logic [9:0]  nf;
    logic        last_frame;
    logic [11:0] col_inc;
    logic [12:0] row_inc;
    logic [11:0] x0p, x1p, dx0, dx1, dy;
    logic        in0, in1;
    logic        cur1;
    logic [ppn_pkg::WX_W-1:0] wx_cur;
    logic        out_hs;

    ppn_pkg::t_acc_req  req   [ppn_pkg::LANES];
    ppn_pkg::t_lane_out lres  [ppn_pkg::LANES];
    ppn_pkg::t_calc_res calc;

    assign acc         = i_valid && (r_state == ppn_pkg::ST_IDLE);
    assign o_stall     = r_state != ppn_pkg::ST_IDLE;
    assign o_cfg_ready = 1'b1;
    assign out_hs      = o_valid && !i_stall;

    always_comb begin
        rw   = (r_row_words == '0) ? 12'd1
             : ((r_row_words > 12'd2048) ? 12'd2048 : r_row_words);
        rows = (r_rows_per_frame == '0) ? 13'd1
             : ((r_rows_per_frame > 13'd4096) ? 13'd4096 : r_rows_per_frame);
        nf   = (r_nf_cfg == '0) ? 10'd1 : r_nf_cfg;
        last_frame = ({1'b0, r_fc} + 11'd1) >= {1'b0, nf};
        col_inc = {1'b0, r_col} + 12'd1;
        row_inc = {1'b0, r_row} + 13'd1;
        x0p = {r_col, 1'b0};
        x1p = {r_col, 1'b1};
        dx0 = x0p - r_x0;
        dx1 = x1p - r_x0;
        dy  = r_row - r_y0;
        in0 = (x0p >= r_x0) && (r_row >= r_y0)
           && (dx0 < 12'(ppn_pkg::WIN_W)) && (dy < 12'(ppn_pkg::WIN_H));
        in1 = (x1p >= r_x0) && (r_row >= r_y0)
           && (dx1 < 12'(ppn_pkg::WIN_W)) && (dy < 12'(ppn_pkg::WIN_H));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_words      <= 12'd1200;
            r_rows_per_frame <= 13'd2800;
            r_x0             <= 12'd1750;
            r_y0             <= 12'd700;
            r_nf_cfg         <= 10'd300;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                ppn_pkg::CFG_ROW_WORDS:      r_row_words      <= i_cfg_data[11:0];
                ppn_pkg::CFG_ROWS_PER_FRAME: r_rows_per_frame <= i_cfg_data[12:0];
                ppn_pkg::CFG_WINDOW_X0:      r_x0             <= i_cfg_data[11:0];
                ppn_pkg::CFG_WINDOW_Y0:      r_y0             <= i_cfg_data[11:0];
                ppn_pkg::CFG_FRAMES_TO_AVG:  r_nf_cfg         <= i_cfg_data[9:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hc <= '0;
            r_col <= '0;
            r_row <= '0;
            r_fc <= '0;
        end else if (acc) begin
            if (r_hc != 2'd2) begin
                r_hc <= r_hc + 2'd1;
            end else if (col_inc >= rw) begin
                r_col <= '0;
                if (row_inc >= rows) begin
                    r_row <= '0;
                    r_hc  <= '0;
                    r_fc  <= last_frame ? 10'd0 : r_fc + 10'd1;
                end else begin
                    r_row <= row_inc[11:0];
                end
            end else begin
                r_col <= col_inc[10:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_pix0  <= {i_raw_word[23:16], i_raw_word[31:24]};
            r_pix1  <= {i_raw_word[7:0], i_raw_word[15:8]};
            r_wx0   <= dx0[ppn_pkg::WX_W-1:0];
            r_wx1   <= dx1[ppn_pkg::WX_W-1:0];
            r_wy    <= dy[ppn_pkg::WY_W-1:0];
            r_emit  <= last_frame;
            r_first <= r_fc == '0;
            r_n     <= ppn_pkg::N_W'(r_fc) + 1'b1;
        end
        if (calc.done) begin
            r_ped   <= calc.ped;
            r_noise <= calc.noise;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else if (acc) begin
            r_pend <= (r_hc == 2'd2) ? {in1, in0} : 2'b00;
        end else if (r_state == ppn_pkg::ST_ACC && !r_emit) begin
            r_pend <= '0;
        end else if (out_hs) begin
            if (r_pend[0]) begin
                r_pend[0] <= 1'b0;
            end else begin
                r_pend[1] <= 1'b0;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ppn_pkg::ST_IDLE:  if (i_valid && r_hc == 2'd2) n_state = ppn_pkg::ST_READ;
            ppn_pkg::ST_READ:  n_state = ppn_pkg::ST_ACC;
            ppn_pkg::ST_ACC:   n_state = (r_emit && r_pend != 2'b00)
                                       ? ppn_pkg::ST_START : ppn_pkg::ST_IDLE;
            ppn_pkg::ST_START: n_state = ppn_pkg::ST_CALC;
            ppn_pkg::ST_CALC:  if (calc.done) n_state = ppn_pkg::ST_OUT;
            ppn_pkg::ST_OUT: begin
                if (!i_stall) begin
                    n_state = (r_pend == 2'b11) ? ppn_pkg::ST_START : ppn_pkg::ST_IDLE;
                end
            end
            default:           n_state = ppn_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ppn_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    for (genvar b = 0; b < ppn_pkg::LANES; b++) begin : g_lane
        logic sel0;
        always_comb begin
            sel0         = r_pend[0] && (r_wx0[0] == 1'(b));
            req[b].we    = (r_state == ppn_pkg::ST_ACC)
                        && (sel0 || (r_pend[1] && (r_wx1[0] == 1'(b))));
            req[b].first = r_first;
            req[b].pix   = sel0 ? r_pix0 : r_pix1;
            req[b].addr  = sel0 ? {r_wy, r_wx0[ppn_pkg::WX_W-1:1]}
                                : {r_wy, r_wx1[ppn_pkg::WX_W-1:1]};
        end
        ppn_lane u_lane (
            .i_clk (i_clk),
            .i_req (req[b]),
            .o_res (lres[b])
        );
    end

    assign cur1   = !r_pend[0];
    assign wx_cur = cur1 ? r_wx1 : r_wx0;

    ppn_stats u_stats (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == ppn_pkg::ST_START),
        .i_sum   (lres[wx_cur[0]].sum),
        .i_sq    (lres[wx_cur[0]].sq),
        .i_n     (r_n),
        .o_res   (calc)
    );

    assign o_valid       = r_state == ppn_pkg::ST_OUT;
    assign o_win_col     = 7'(wx_cur);
    assign o_win_row     = 7'(r_wy);
    assign o_pedestal_q8 = r_ped;
    assign o_noise_q8    = r_noise;
    assign o_last        = r_pend != 2'b11;

    a_bank_split: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ppn_pkg::ST_ACC && r_pend == 2'b11) |-> (r_wx0[0] != r_wx1[0]))
        else $error("both pixels of a word map to one bank");
    a_done_in_calc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        calc.done |-> (r_state == ppn_pkg::ST_CALC))
        else $error("stats result outside calc state");
    a_out_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_emit && r_pend != 2'b00))
        else $error("result shown with nothing pending");
endmodule
`default_nettype wire

[rtl/ppn_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module ppn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

[rtl/ppn_lane.sv]
// One accumulation lane: sum and sum-of-squares bank for one column parity.
`timescale 1ns / 1ps
`default_nettype none
module ppn_lane (
    input  wire logic              i_clk,
    input  wire ppn_pkg::t_acc_req i_req,
    output      ppn_pkg::t_lane_out o_res
);
    logic [ppn_pkg::SUM_W-1:0] rd_sum;
    logic [ppn_pkg::SQ_W-1:0]  rd_sq;
    logic [ppn_pkg::SUM_W-1:0] n_sum;
    logic [ppn_pkg::SQ_W-1:0]  n_sq;
    logic [ppn_pkg::SQ_W-1:0]  pix_sq;
    logic [ppn_pkg::SUM_W-1:0] r_sum;
    logic [ppn_pkg::SQ_W-1:0]  r_sq;

    ppn_ram #(.WIDTH(ppn_pkg::SUM_W), .DEPTH(ppn_pkg::BANK_DEPTH)) u_sum_ram (
        .i_clk   (i_clk),
        .i_we    (i_req.we),
        .i_waddr (i_req.addr),
        .i_wdata (n_sum),
        .i_raddr (i_req.addr),
        .o_rdata (rd_sum)
    );

    ppn_ram #(.WIDTH(ppn_pkg::SQ_W), .DEPTH(ppn_pkg::BANK_DEPTH)) u_sq_ram (
        .i_clk   (i_clk),
        .i_we    (i_req.we),
        .i_waddr (i_req.addr),
        .i_wdata (n_sq),
        .i_raddr (i_req.addr),
        .o_rdata (rd_sq)
    );

    always_comb begin
        pix_sq = ppn_pkg::SQ_W'(i_req.pix) * ppn_pkg::SQ_W'(i_req.pix);
        if (i_req.first) begin
            n_sum = ppn_pkg::SUM_W'(i_req.pix);
            n_sq  = pix_sq;
        end else begin
            n_sum = rd_sum + ppn_pkg::SUM_W'(i_req.pix);
            n_sq  = rd_sq + pix_sq;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_sum <= n_sum;
            r_sq  <= n_sq;
        end
    end

    assign o_res.sum = r_sum;
    assign o_res.sq  = r_sq;
endmodule
`default_nettype wire

[rtl/ppn_stats.sv]
// Iterative pedestal divide, variance divide and square root unit.
`timescale 1ns / 1ps
`default_nettype none
module ppn_stats (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    input  wire logic [ppn_pkg::SUM_W-1:0] i_sum,
    input  wire logic [ppn_pkg::SQ_W-1:0]  i_sq,
    input  wire logic [ppn_pkg::N_W-1:0]   i_n,
    output      ppn_pkg::t_calc_res        o_res
);
    ppn_pkg::t_calc_state r_state, n_state;
    logic [ppn_pkg::SUM_W-1:0]       r_sum;
    logic [ppn_pkg::SQ_W-1:0]        r_sq;
    logic [ppn_pkg::N_W-1:0]         r_n;
    logic [ppn_pkg::SQ_W+ppn_pkg::N_W-1:0] r_nsq;
    logic [2*ppn_pkg::SUM_W-1:0]     r_ssq;
    logic [2*ppn_pkg::N_W-1:0]       r_n2;
    logic [ppn_pkg::DIV_W-1:0]       r_dvd;
    logic [ppn_pkg::REM_W-1:0]       r_dvs;
    logic [ppn_pkg::REM_W-1:0]       r_rem;
    logic [ppn_pkg::DIV_W-1:0]       r_q;
    logic [ppn_pkg::CNT_W-1:0]       r_cnt;
    logic [ppn_pkg::RT_W-1:0]        r_sv;
    logic [ppn_pkg::RT_W-1:0]        r_sr;
    logic [ppn_pkg::RT_W-1:0]        r_sb;
    logic                            r_done;
    logic [ppn_pkg::Q8_W-1:0]        r_ped;
    logic [ppn_pkg::Q8_W-1:0]        r_noise;

    logic [ppn_pkg::REM_W:0]         rem_sh;
    logic                            ge;
    logic [ppn_pkg::REM_W-1:0]       n_rem;
    logic [ppn_pkg::DIV_W-1:0]       n_q;
    logic [ppn_pkg::SQ_W+ppn_pkg::N_W-1:0] num;
    logic [ppn_pkg::RT_W-1:0]        rt_t;
    logic                            rt_ge;
    logic [ppn_pkg::RT_W-1:0]        n_sv;
    logic [ppn_pkg::RT_W-1:0]        n_sr;
    logic                            div_end;
    logic                            rt_end;

    always_comb begin
        rem_sh  = {r_rem, r_dvd[ppn_pkg::DIV_W-1]};
        ge      = rem_sh >= {1'b0, r_dvs};
        n_rem   = ge ? ppn_pkg::REM_W'(rem_sh - {1'b0, r_dvs})
                     : ppn_pkg::REM_W'(rem_sh);
        n_q     = {r_q[ppn_pkg::DIV_W-2:0], ge};
        num     = (r_nsq > (ppn_pkg::SQ_W+ppn_pkg::N_W)'(r_ssq))
                ? r_nsq - (ppn_pkg::SQ_W+ppn_pkg::N_W)'(r_ssq) : '0;
        rt_t    = r_sr + r_sb;
        rt_ge   = r_sv >= rt_t;
        n_sv    = rt_ge ? r_sv - rt_t : r_sv;
        n_sr    = rt_ge ? (r_sr >> 1) + r_sb : r_sr >> 1;
        div_end = r_cnt == ppn_pkg::CNT_W'(ppn_pkg::DIV_STEPS - 1);
        rt_end  = r_cnt == ppn_pkg::CNT_W'(ppn_pkg::SQRT_STEPS - 1);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ppn_pkg::CS_IDLE: if (i_start) n_state = ppn_pkg::CS_MUL;
            ppn_pkg::CS_MUL:  n_state = ppn_pkg::CS_DIVP;
            ppn_pkg::CS_DIVP: if (div_end) n_state = ppn_pkg::CS_VAR;
            ppn_pkg::CS_VAR:  n_state = ppn_pkg::CS_DIVV;
            ppn_pkg::CS_DIVV: if (div_end) n_state = ppn_pkg::CS_SQRT;
            ppn_pkg::CS_SQRT: if (rt_end) n_state = ppn_pkg::CS_IDLE;
            default:          n_state = ppn_pkg::CS_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ppn_pkg::CS_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == ppn_pkg::CS_SQRT) && rt_end;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ppn_pkg::CS_IDLE: begin
                r_sum <= i_sum;
                r_sq  <= i_sq;
                r_n   <= i_n;
            end
            ppn_pkg::CS_MUL: begin
                r_nsq <= (ppn_pkg::SQ_W+ppn_pkg::N_W)'(r_n)
                       * (ppn_pkg::SQ_W+ppn_pkg::N_W)'(r_sq);
                r_ssq <= (2*ppn_pkg::SUM_W)'(r_sum) * (2*ppn_pkg::SUM_W)'(r_sum);
                r_n2  <= (2*ppn_pkg::N_W)'(r_n) * (2*ppn_pkg::N_W)'(r_n);
                r_dvd <= ppn_pkg::DIV_W'({r_sum, 8'd0}) + ppn_pkg::DIV_W'(r_n >> 1);
                r_dvs <= ppn_pkg::REM_W'(r_n);
                r_rem <= '0;
                r_q   <= '0;
                r_cnt <= '0;
            end
            ppn_pkg::CS_DIVP, ppn_pkg::CS_DIVV: begin
                r_rem <= n_rem;
                r_q   <= n_q;
                r_dvd <= r_dvd << 1;
                r_cnt <= r_cnt + 1'b1;
                if (div_end && r_state == ppn_pkg::CS_DIVP) begin
                    r_ped <= (|n_q[ppn_pkg::DIV_W-1:ppn_pkg::Q8_W])
                           ? '1 : n_q[ppn_pkg::Q8_W-1:0];
                end
                if (div_end && r_state == ppn_pkg::CS_DIVV) begin
                    r_sv  <= (|n_q[ppn_pkg::DIV_W-1:48])
                           ? ppn_pkg::RT_W'(1) << 48 : ppn_pkg::RT_W'(n_q[48:0]);
                    r_sr  <= '0;
                    r_sb  <= ppn_pkg::RT_W'(1) << 48;
                    r_cnt <= '0;
                end
            end
            ppn_pkg::CS_VAR: begin
                r_dvd <= {num, 16'd0};
                r_dvs <= r_n2;
                r_rem <= '0;
                r_q   <= '0;
                r_cnt <= '0;
            end
            ppn_pkg::CS_SQRT: begin
                r_sv  <= n_sv;
                r_sr  <= n_sr;
                r_sb  <= r_sb >> 2;
                r_cnt <= r_cnt + 1'b1;
                if (rt_end) begin
                    r_noise <= (|n_sr[ppn_pkg::RT_W-1:ppn_pkg::Q8_W])
                             ? '1 : n_sr[ppn_pkg::Q8_W-1:0];
                end
            end
            default: begin
                r_cnt <= '0;
            end
        endcase
    end

    assign o_res.done  = r_done;
    assign o_res.ped   = r_ped;
    assign o_res.noise = r_noise;
endmodule
`default_nettype wire

[dv/tb_pixel_pedestal_noise_calc.sv]
// Self-checking testbench of the pixel pedestal and noise block.
`timescale 1ns / 1ps
module tb_pixel_pedestal_noise_calc;
    typedef struct packed {
        logic [6:0]  col;
        logic [6:0]  row;
        logic [23:0] ped;
        logic [23:0] noise;
        logic        last;
    } t_pix_stat;

    typedef struct packed {
        logic [31:0] word;
        logic        typed;
        logic [23:0] ped0;
        logic [23:0] ped1;
    } t_dir_row;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_valid = 1'b0;
    logic                           o_stall;
    logic [31:0]                    i_raw_word = '0;
    logic                           o_valid;
    logic                           i_stall = 1'b0;
    logic [6:0]                     o_win_col;
    logic [6:0]                     o_win_row;
    logic [23:0]                    o_pedestal_q8;
    logic [23:0]                    o_noise_q8;
    logic                           o_last;
    logic                           i_cfg_valid = 1'b0;
    logic                           o_cfg_ready;
    logic [ppn_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [ppn_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    pixel_pedestal_noise_calc uut (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    initial begin
        #20ms;
        $display("tb_pixel_pedestal_noise_calc: errors");
        $finish;
    end

    // predictor state
    logic [11:0] cfg_rw;
    logic [12:0] cfg_rows;
    logic [11:0] cfg_x0, cfg_y0;
    logic [9:0]  cfg_nf;
    int unsigned hdr_cnt, col_pos, row_pos, frame_cnt;
    logic [25:0] sum_mem [ppn_pkg::WIN_W*ppn_pkg::WIN_H];
    logic [41:0] sq_mem [ppn_pkg::WIN_W*ppn_pkg::WIN_H];
    t_pix_stat   stat_q[$];
    t_pix_stat   step_res[2];
    int          step_n;
    int          errors = 0;
    int          items = 0;
    bit          quiet = 0;
    bit          hold_arm = 0;

    function automatic logic [63:0] isqrt(logic [63:0] v);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    task automatic take_pixel(int unsigned x, int unsigned y, logic [15:0] pix, bit emit);
        int unsigned wx, wy;
        logic [13:0] idx;
        logic [63:0] s, q, n, ped, num, n2, a, b, v, nz;
        if (x < cfg_x0 || y < cfg_y0) return;
        wx = x - 32'(cfg_x0);
        wy = y - 32'(cfg_y0);
        if (wx >= ppn_pkg::WIN_W || wy >= ppn_pkg::WIN_H) return;
        idx = 14'(wy * ppn_pkg::WIN_W + wx);
        if (frame_cnt == 0) begin
            sum_mem[idx] = 26'(pix);
            sq_mem[idx] = 42'(pix) * 42'(pix);
        end else begin
            sum_mem[idx] = sum_mem[idx] + 26'(pix);
            sq_mem[idx] = sq_mem[idx] + 42'(pix) * 42'(pix);
        end
        if (!emit) return;
        s = 64'(sum_mem[idx]);
        q = 64'(sq_mem[idx]);
        n = 64'(frame_cnt) + 64'd1;
        ped = (s * 64'd256 + n / 64'd2) / n;
        if (ped > 64'hFFFFFF) ped = 64'hFFFFFF;
        num = n * q;
        num = (num > s * s) ? num - s * s : 64'd0;
        n2 = n * n;
        a = num / n2;
        b = num % n2;
        if (a >= (64'd1 << 32)) v = 64'd1 << 48;
        else v = (a << 16) + ((b << 16) / n2);
        nz = isqrt(v);
        if (nz > 64'hFFFFFF) nz = 64'hFFFFFF;
        step_res[1'(step_n)] = '{col: wx[6:0], row: wy[6:0], ped: ped[23:0],
                                 noise: nz[23:0], last: 1'b0};
        step_n++;
    endtask

    task automatic predict_word(logic [31:0] w, bit keep);
        int unsigned rw, rows, nf;
        bit lf;
        step_n = 0;
        if (hdr_cnt < 2) begin
            hdr_cnt++;
            return;
        end
        rw = cfg_rw == 0 ? 1 : (cfg_rw > 2048 ? 2048 : cfg_rw);
        rows = cfg_rows == 0 ? 1 : (cfg_rows > 4096 ? 4096 : cfg_rows);
        nf = cfg_nf == 0 ? 1 : cfg_nf;
        lf = frame_cnt + 1 >= nf;
        take_pixel(col_pos * 2, row_pos, {w[23:16], w[31:24]}, lf);
        take_pixel(col_pos * 2 + 1, row_pos, {w[7:0], w[15:8]}, lf);
        if (step_n > 0) step_res[1'(step_n-1)].last = 1'b1;
        if (keep) for (int i = 0; i < step_n; i++) stat_q.push_back(step_res[1'(i)]);
        col_pos++;
        if (col_pos >= rw) begin
            col_pos = 0;
            row_pos++;
            if (row_pos >= rows) begin
                row_pos = 0;
                hdr_cnt = 0;
                frame_cnt = lf ? 0 : ((frame_cnt + 1) & 32'h3FF);
            end
        end
    endtask

    function automatic int pick_gap();
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_word(logic [31:0] w, bit keep);
        int g;
        i_valid <= 1'b1;
        i_raw_word <= w;
        do @(posedge i_clk); while (o_stall);
        items++;
        predict_word(w, keep);
        g = pick_gap();
        if (g > 0) begin
            i_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    task automatic write_reg(logic [ppn_pkg::CFG_IDX_W-1:0] idx,
                             logic [ppn_pkg::CFG_DATA_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            ppn_pkg::CFG_ROW_WORDS:      cfg_rw = val[11:0];
            ppn_pkg::CFG_ROWS_PER_FRAME: cfg_rows = val;
            ppn_pkg::CFG_WINDOW_X0:      cfg_x0 = val[11:0];
            ppn_pkg::CFG_WINDOW_Y0:      cfg_y0 = val[11:0];
            ppn_pkg::CFG_FRAMES_TO_AVG:  cfg_nf = val[9:0];
            default: ;
        endcase
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (stat_q.size() != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
    endtask

    task automatic set_all(int rw, int rows, int x0, int y0, int nf);
        drain();
        write_reg(ppn_pkg::CFG_ROW_WORDS, ppn_pkg::CFG_DATA_W'(rw));
        write_reg(ppn_pkg::CFG_ROWS_PER_FRAME, ppn_pkg::CFG_DATA_W'(rows));
        write_reg(ppn_pkg::CFG_WINDOW_X0, ppn_pkg::CFG_DATA_W'(x0));
        write_reg(ppn_pkg::CFG_WINDOW_Y0, ppn_pkg::CFG_DATA_W'(y0));
        write_reg(ppn_pkg::CFG_FRAMES_TO_AVG, ppn_pkg::CFG_DATA_W'(nf));
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] rand_word();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return 32'h0;
        if (r == 1) return 32'hFFFF_FFFF;
        return $urandom;
    endfunction

    task automatic send_n(int n);
        repeat (n) send_word(rand_word(), 1);
    endtask

    task automatic run_frames(int runs);
        int rw, rows, nf;
        rw = cfg_rw == 0 ? 1 : (cfg_rw > 2048 ? 2048 : cfg_rw);
        rows = cfg_rows == 0 ? 1 : (cfg_rows > 4096 ? 4096 : cfg_rows);
        nf = cfg_nf == 0 ? 1 : cfg_nf;
        repeat (runs * nf) begin
            send_word(rand_word(), 1);
            send_word(rand_word(), 1);
            repeat (rw * rows) send_word(rand_word(), 1);
        end
    endtask

    // results side
    int hold_cnt = 0;
    int taken = 0;
    bit held = 0;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                taken++;
                if (stat_q.size() == 0) begin
                    $display("%0t: unexpected result col=%0d row=%0d", $realtime,
                             o_win_col, o_win_row);
                    errors++;
                end else begin
                    t_pix_stat e;
                    e = stat_q.pop_front();
                    if (e.col !== o_win_col)
                        $display("%0t: col exp %0d got %0d", $realtime, e.col, o_win_col);
                    if (e.row !== o_win_row)
                        $display("%0t: row exp %0d got %0d", $realtime, e.row, o_win_row);
                    if (e.ped !== o_pedestal_q8)
                        $display("%0t: pedestal exp %h got %h", $realtime, e.ped,
                                 o_pedestal_q8);
                    if (e.noise !== o_noise_q8)
                        $display("%0t: noise exp %h got %h", $realtime, e.noise, o_noise_q8);
                    if (e.last !== o_last)
                        $display("%0t: last exp %b got %b", $realtime, e.last, o_last);
                    if (e !== {o_win_col, o_win_row, o_pedestal_q8, o_noise_q8, o_last})
                        errors++;
                end
            end
            if (hold_cnt > 0) begin
                hold_cnt <= hold_cnt - 1;
                i_stall <= 1'b1;
            end else if (!held && hold_arm && o_valid) begin
                held <= 1'b1;
                hold_cnt <= 600;
                i_stall <= 1'b1;
            end else begin
                i_stall <= quiet ? 1'b0 : (pick_gap() > 0);
            end
        end
    end

    t_dir_row dir_rows[16] = '{
        '{32'h0000_0000, 1, 24'h0, 24'h0},
        '{32'h0000_0000, 1, 24'h0, 24'h0},
        '{32'h0000_0000, 1, 24'h000000, 24'h000000},
        '{32'hFFFF_FFFF, 1, 24'h0, 24'h0},
        '{32'hFFFF_FFFF, 1, 24'h0, 24'h0},
        '{32'hFFFF_FFFF, 1, 24'hFFFF00, 24'hFFFF00},
        '{32'h1234_5678, 1, 24'h0, 24'h0},
        '{32'h1234_5678, 1, 24'h0, 24'h0},
        '{32'h1234_5678, 1, 24'h341200, 24'h785600},
        '{32'hFF00_00FF, 1, 24'h0, 24'h0},
        '{32'hFF00_00FF, 1, 24'h0, 24'h0},
        '{32'hFF00_00FF, 1, 24'h00FF00, 24'hFF0000},
        '{32'hA5A5_A5A5, 0, 24'h0, 24'h0},
        '{32'h5A5A_5A5A, 0, 24'h0, 24'h0},
        '{32'h8000_0001, 0, 24'h0, 24'h0},
        '{32'h0000_0000, 0, 24'h0, 24'h0}
    };

    initial begin
        int rw, rows, x0, y0, nf;
        cfg_rw = 1200;
        cfg_rows = 2800;
        cfg_x0 = 1750;
        cfg_y0 = 700;
        cfg_nf = 300;
        hdr_cnt = 0;
        col_pos = 0;
        row_pos = 0;
        frame_cnt = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_all(1, 1, 0, 0, 1);
        foreach (dir_rows[i]) begin
            send_word(dir_rows[i].word, !dir_rows[i].typed);
            if (dir_rows[i].typed && step_n == 2) begin
                stat_q.push_back('{col: 7'd0, row: 7'd0, ped: dir_rows[i].ped0,
                                   noise: 24'd0, last: 1'b0});
                stat_q.push_back('{col: 7'd1, row: 7'd0, ped: dir_rows[i].ped1,
                                   noise: 24'd0, last: 1'b1});
            end
        end

        // extremes of the registers
        set_all(0, 0, 0, 0, 0);
        run_frames(1);
        set_all(2, 2, 1, 1, 1023);
        send_n(60);
        set_all(2, 2, 1, 1, 1);
        run_frames(1);
        set_all(3, 2, 4095, 4095, 1);
        run_frames(1);

        hold_arm = 1;
        while (items < 1000) begin
            rw = $urandom_range(1, 4);
            rows = $urandom_range(1, 3);
            x0 = $urandom_range(0, 9) == 0 ? $urandom_range(0, 4095) : $urandom_range(0, 6);
            y0 = $urandom_range(0, 9) == 0 ? $urandom_range(0, 4095) : $urandom_range(0, 2);
            nf = $urandom_range(1, 5);
            quiet = ($urandom_range(0, 4) == 0);
            set_all(rw, rows, x0, y0, nf);
            run_frames($urandom_range(1, 3));
        end
        quiet = 0;

        drain();
        if (errors == 0 && stat_q.size() == 0) begin
            $display("tb_pixel_pedestal_noise_calc: clean");
        end else begin
            $display("tb_pixel_pedestal_noise_calc: errors");
        end
        $finish;
    end
endmodule
